// ===== hw/rtl/cce_pkg.sv =====
// ----------------------------------------------------------------------------
// cce_pkg
// Shared types, constants and helpers for the control character escaper.
// ----------------------------------------------------------------------------
package cce_pkg;

  localparam int unsigned BYTE_W              = 8;
  localparam int unsigned CAP_W               = 13;
  localparam int unsigned CFG_IDX_W           = 1;
  localparam int unsigned ESC_MAX             = 4;
  localparam int unsigned LEN_W               = 3;
  localparam int unsigned MAX_OUTPUT_SIZE_DEF = 4096;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PLAIN_MODE   = 1'b0,
    CFG_OUT_CAPACITY = 1'b1
  } cfg_idx_t;

  localparam logic             PLAIN_MODE_RST   = 1'b1;
  localparam logic [CAP_W-1:0] OUT_CAPACITY_RST = 13'd256;

  // Character codes
  localparam logic [BYTE_W-1:0] CH_NUL    = 8'h00;
  localparam logic [BYTE_W-1:0] CH_BSLASH = 8'h5c;
  localparam logic [BYTE_W-1:0] CH_DQUOTE = 8'h22;
  localparam logic [BYTE_W-1:0] CH_LF     = 8'h0a;
  localparam logic [BYTE_W-1:0] CH_TAB    = 8'h09;
  localparam logic [BYTE_W-1:0] CH_CR     = 8'h0d;
  localparam logic [BYTE_W-1:0] CH_SPACE  = 8'h20;
  localparam logic [BYTE_W-1:0] CH_N      = 8'h6e;
  localparam logic [BYTE_W-1:0] CH_T      = 8'h74;
  localparam logic [BYTE_W-1:0] CH_R      = 8'h72;
  localparam logic [BYTE_W-1:0] CH_X      = 8'h78;
  localparam logic [BYTE_W-1:0] CH_ZERO   = 8'h30;
  localparam logic [BYTE_W-1:0] CH_A_M10  = 8'h57;  // 'a' - 10

  // One escape sequence, byte 0 goes out first
  typedef struct packed {
    logic [ESC_MAX-1:0][BYTE_W-1:0] bytes;
    logic [LEN_W-1:0]               len;
  } esc_t;

  // Lower-case hex digit of a nibble
  function automatic logic [BYTE_W-1:0] hex_digit(input logic [3:0] v);
    logic [BYTE_W-1:0] ext;
    ext = {4'h0, v};
    return (v < 4'd10) ? (CH_ZERO + ext) : (CH_A_M10 + ext);
  endfunction

endpackage

// ===== hw/rtl/cce_in_if.sv =====
// ----------------------------------------------------------------------------
// cce_in_if
// Input byte channel: valid/ready handshake with one string byte.
// ----------------------------------------------------------------------------
interface cce_in_if import cce_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] in_byte;

  modport source (output valid, output in_byte, input ready);
  modport sink   (input valid, input in_byte, output ready);
endinterface

// ===== hw/rtl/cce_out_if.sv =====
// ----------------------------------------------------------------------------
// cce_out_if
// Result channel: valid/ready handshake with one emitted byte and its flags.
// ----------------------------------------------------------------------------
interface cce_out_if import cce_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] out_byte;
  logic              run_last;
  logic              is_terminator;

  modport source (output valid, output out_byte, output run_last,
                  output is_terminator, input ready);
  modport sink   (input valid, input out_byte, input run_last,
                  input is_terminator, output ready);
endinterface

// ===== hw/rtl/cce_escape_enc.sv =====
// ----------------------------------------------------------------------------
// cce_escape_enc
// Maps one non-zero string byte to its escape sequence (1, 2 or 4 bytes).
// ----------------------------------------------------------------------------
module cce_escape_enc import cce_pkg::*; (
  input  logic [BYTE_W-1:0] byte_in,
  input  logic              plain_mode,
  output esc_t              esc
);

  always_comb begin
    esc = '0;
    priority if (byte_in == CH_BSLASH || byte_in == CH_DQUOTE) begin
      esc.bytes[0] = CH_BSLASH;
      esc.bytes[1] = byte_in;
      esc.len      = 3'd2;
    end else if (byte_in == CH_LF) begin
      esc.bytes[0] = CH_BSLASH;
      esc.bytes[1] = CH_N;
      esc.len      = 3'd2;
    end else if (plain_mode && byte_in == CH_TAB) begin
      esc.bytes[0] = CH_BSLASH;
      esc.bytes[1] = CH_T;
      esc.len      = 3'd2;
    end else if (plain_mode && byte_in == CH_CR) begin
      esc.bytes[0] = CH_BSLASH;
      esc.bytes[1] = CH_R;
      esc.len      = 3'd2;
    end else if (plain_mode && byte_in < CH_SPACE) begin
      // other C0 control: \xHH
      esc.bytes[0] = CH_BSLASH;
      esc.bytes[1] = CH_X;
      esc.bytes[2] = hex_digit(byte_in[7:4]);
      esc.bytes[3] = hex_digit(byte_in[3:0]);
      esc.len      = 3'd4;
    end else begin
      esc.bytes[0] = byte_in;
      esc.len      = 3'd1;
    end
  end

endmodule

// ===== hw/rtl/control_char_escaper.sv =====
// ----------------------------------------------------------------------------
// control_char_escaper
// Escapes a NUL-terminated byte string for display, bounded by a capacity.
// ----------------------------------------------------------------------------
// Usage:
//   in_chan  : one string byte per transaction; a zero byte ends the string.
//   out_chan : one emitted byte per transaction, with run_last on the final
//              byte caused by an input byte and is_terminator on the NUL.
//   cfg_*    : write-only registers (plain_mode, out_capacity), written
//              while the block is idle.
// Path: the first output byte of an input byte goes from the sequence
//   register to the output register.
// Throughput: an input byte whose escape is L bytes long holds the
//   sequence register until its L bytes have moved out; the next input
//   byte is taken in the cycle its last byte moves to the output
//   register. Plain bytes go at one per cycle while out_chan.ready stays
//   high; bytes dropped by truncation are taken and emit nothing.
// Stall: while out_chan.ready is low the output register holds its byte,
//   the sequence register holds one more input byte, and in_chan.ready
//   drops once both are full.
// Reset: clears the count, the truncation flag and both valid stages and
//   loads plain_mode = 1, out_capacity = 256.
// ----------------------------------------------------------------------------
module control_char_escaper import cce_pkg::*; #(
  parameter int unsigned MAX_OUTPUT_SIZE = MAX_OUTPUT_SIZE_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  cce_in_if.sink               in_chan,
  cce_out_if.source            out_chan,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_idx,
  input  logic [CAP_W-1:0]     cfg_wdata
);

  // Configuration registers
  logic             plain_mode_r;
  logic [CAP_W-1:0] out_capacity_r;

  // String state
  logic [CAP_W-1:0] wcount_r, wcount_nxt;
  logic             trunc_r, trunc_nxt;

  // Sequence register: pending escape bytes, byte 0 next out
  logic [ESC_MAX-1:0][BYTE_W-1:0] seq_bytes_r, seq_bytes_nxt;
  logic [LEN_W-1:0]               seq_rem_r, seq_rem_nxt;
  logic                           seq_term_r, seq_term_nxt;

  // Output register
  logic              out_valid_r;
  logic [BYTE_W-1:0] out_byte_r;
  logic              out_last_r;
  logic              out_term_r;

  esc_t             esc;
  logic [CAP_W-1:0] cap_eff;
  logic [CAP_W:0]   sum;
  logic             fits;
  logic             seq_mv;
  logic             in_ready;
  logic             accept;
  logic             is_end;

  cce_escape_enc u_enc (
    .byte_in    (in_chan.in_byte),
    .plain_mode (plain_mode_r),
    .esc        (esc)
  );

  // Handshake
  assign seq_mv   = (seq_rem_r != '0) && (!out_valid_r || out_chan.ready);
  assign in_ready = (seq_rem_r == '0) || ((seq_rem_r == LEN_W'(1)) && seq_mv);
  assign accept   = in_chan.valid && in_ready;
  assign is_end   = (in_chan.in_byte == CH_NUL);

  // Capacity check
  assign cap_eff = (32'(out_capacity_r) > MAX_OUTPUT_SIZE) ?
                   CAP_W'(MAX_OUTPUT_SIZE) : out_capacity_r;
  assign sum     = {1'b0, wcount_r} + (CAP_W+1)'(esc.len);
  assign fits    = sum < {1'b0, cap_eff};

  // Next state of string state and sequence register
  always_comb begin
    wcount_nxt    = wcount_r;
    trunc_nxt     = trunc_r;
    seq_bytes_nxt = seq_bytes_r;
    seq_rem_nxt   = seq_rem_r;
    seq_term_nxt  = seq_term_r;
    if (seq_mv) begin
      seq_bytes_nxt = seq_bytes_r >> BYTE_W;
      seq_rem_nxt   = seq_rem_r - LEN_W'(1);
    end
    if (accept) begin
      priority if (is_end) begin
        seq_bytes_nxt = '0;
        seq_rem_nxt   = LEN_W'(1);
        seq_term_nxt  = 1'b1;
        wcount_nxt    = '0;
        trunc_nxt     = 1'b0;
      end else if (trunc_r) begin
        // string already cut: drop
      end else if (fits) begin
        seq_bytes_nxt = esc.bytes;
        seq_rem_nxt   = esc.len;
        seq_term_nxt  = 1'b0;
        wcount_nxt    = sum[CAP_W-1:0];
      end else begin
        trunc_nxt = 1'b1;
      end
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      plain_mode_r   <= PLAIN_MODE_RST;
      out_capacity_r <= OUT_CAPACITY_RST;
      wcount_r       <= '0;
      trunc_r        <= 1'b0;
      seq_rem_r      <= '0;
      out_valid_r    <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_idx)
          CFG_PLAIN_MODE:   plain_mode_r   <= cfg_wdata[0];
          CFG_OUT_CAPACITY: out_capacity_r <= cfg_wdata;
          default:          ;
        endcase
      end
      wcount_r  <= wcount_nxt;
      trunc_r   <= trunc_nxt;
      seq_rem_r <= seq_rem_nxt;
      if (seq_mv) begin
        out_valid_r <= 1'b1;
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    seq_bytes_r <= seq_bytes_nxt;
    seq_term_r  <= seq_term_nxt;
    if (seq_mv) begin
      out_byte_r <= seq_bytes_r[0];
      out_last_r <= (seq_rem_r == LEN_W'(1));
      out_term_r <= seq_term_r;
    end
  end

  assign in_chan.ready          = in_ready;
  assign out_chan.valid         = out_valid_r;
  assign out_chan.out_byte      = out_byte_r;
  assign out_chan.run_last      = out_last_r;
  assign out_chan.is_terminator = out_term_r;

`ifndef SYNTH
  // Sequence register never holds more than one full escape
  a_seq_rem_max: assert property (@(posedge clk) disable iff (!rst_n)
    seq_rem_r <= LEN_W'(ESC_MAX))
    else $error("sequence register overfilled");

  // End of string clears count and truncation
  a_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && is_end) |=> (wcount_r == '0 && !trunc_r))
    else $error("string state not cleared at terminator");

  // Terminator is always the last byte of its input byte
  a_term_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_term_r) |-> out_last_r)
    else $error("terminator without run_last");

  // Truncation only clears on a terminator
  a_trunc_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (trunc_r && !(accept && is_end)) |=> trunc_r)
    else $error("truncation flag dropped mid-string");
`endif

endmodule

// ===== verif/escape_checker.sv =====
// ----------------------------------------------------------------------------
// escape_checker
// Watches the byte and result channels and the register port of the escaper,
// predicts the escaped output of every input byte and compares it in order.
// ----------------------------------------------------------------------------
module escape_checker import cce_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  cce_in_if                    in_mon,
  cce_out_if                   out_mon,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_idx,
  input  logic [CAP_W-1:0]     cfg_wdata,
  output int unsigned          fail_count,
  output int unsigned          pending_count
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [BYTE_W-1:0] CH_LOWER_A = 8'h61;
  localparam int unsigned       MAX_REPORTS = 10;

  typedef struct packed {
    logic [BYTE_W-1:0] data;
    logic              last;
    logic              term;
  } out_beat_t;

  // Mirror of the block's registers and string state
  logic             plain_mode;
  logic [CAP_W-1:0] out_capacity;
  int unsigned      written_count;
  logic             truncated;

  out_beat_t escaped_q[$];
  out_beat_t want_beat, got_beat;

  function automatic logic [BYTE_W-1:0] nibble_char(input logic [3:0] n);
    return (n < 4'd10) ? CH_ZERO + {4'h0, n} : CH_LOWER_A + {4'h0, n} - 8'd10;
  endfunction

  // Expand one input byte into the bytes it should produce
  task automatic escape_byte(input logic [BYTE_W-1:0] c);
    logic [BYTE_W-1:0] seq [ESC_MAX];
    int unsigned       len;
    int unsigned       cap;
    cap = (out_capacity > MAX_OUTPUT_SIZE_DEF) ? MAX_OUTPUT_SIZE_DEF : out_capacity;
    // End of string: terminator always goes out, state clears
    if (c == CH_NUL) begin
      escaped_q.push_back('{data: CH_NUL, last: 1'b1, term: 1'b1});
      written_count = 0;
      truncated     = 1'b0;
      return;
    end
    if (truncated)
      return;
    seq[0] = c;
    len    = 1;
    if (c == CH_BSLASH || c == CH_DQUOTE) begin
      seq[0] = CH_BSLASH; seq[1] = c; len = 2;
    end else if (c == CH_LF) begin
      seq[0] = CH_BSLASH; seq[1] = CH_N; len = 2;
    end else if (plain_mode && c == CH_TAB) begin
      seq[0] = CH_BSLASH; seq[1] = CH_T; len = 2;
    end else if (plain_mode && c == CH_CR) begin
      seq[0] = CH_BSLASH; seq[1] = CH_R; len = 2;
    end else if (plain_mode && c < CH_SPACE) begin
      seq[0] = CH_BSLASH;
      seq[1] = CH_X;
      seq[2] = nibble_char(c[7:4]);
      seq[3] = nibble_char(c[3:0]);
      len    = 4;
    end
    // The whole escape plus the terminator must fit
    if (written_count + len >= cap) begin
      truncated = 1'b1;
      return;
    end
    for (int unsigned i = 0; i < len; i++)
      escaped_q.push_back('{data: seq[i], last: (i + 1 == len), term: 1'b0});
    written_count = (written_count + len) & 32'h1fff;
  endtask

  task automatic report(input string what);
    fail_count++;
    if (fail_count <= MAX_REPORTS)
      $display("%0t: %s: expected byte %h last %b term %b, got byte %h last %b term %b",
               $realtime, what, want_beat.data, want_beat.last, want_beat.term,
               got_beat.data, got_beat.last, got_beat.term);
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      plain_mode    = PLAIN_MODE_RST;
      out_capacity  = OUT_CAPACITY_RST;
      written_count = 0;
      truncated     = 1'b0;
      escaped_q.delete();
    end else begin
      // Register writes only happen while idle
      if (cfg_we) begin
        case (cfg_idx_t'(cfg_idx))
          CFG_PLAIN_MODE:   plain_mode   = cfg_wdata[0];
          CFG_OUT_CAPACITY: out_capacity = cfg_wdata;
          default: ;
        endcase
      end
      if (in_mon.valid && in_mon.ready)
        escape_byte(in_mon.in_byte);
      // Compare each result transaction with the oldest prediction
      if (out_mon.valid && out_mon.ready) begin
        got_beat = '{data: out_mon.out_byte, last: out_mon.run_last,
                     term: out_mon.is_terminator};
        if (escaped_q.size() == 0) begin
          want_beat = '0;
          report("unexpected result");
        end else begin
          want_beat = escaped_q.pop_front();
          if (got_beat.data != want_beat.data)
            report("out_byte mismatch");
          else if (got_beat.last != want_beat.last)
            report("run_last mismatch");
          else if (got_beat.term != want_beat.term)
            report("is_terminator mismatch");
        end
      end
    end
    pending_count <= escaped_q.size();
  end

endmodule

// ===== verif/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Drives strings into the escaper with random gaps on both channels, walks
// through escape modes and capacities, and reports the checker's verdict.
// ----------------------------------------------------------------------------
module testbench import cce_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  typedef logic [BYTE_W-1:0] byte_t;

  localparam int unsigned STALL_LIMIT     = 2000;
  localparam int unsigned HOLD_OFF_CYCLES = 80;
  localparam int unsigned SETTLE_CYCLES   = 8;
  localparam int unsigned PHASE_ITEMS     = 13;
  localparam int unsigned CLAMP_ITEMS     = 6;
  localparam int          PRESSURE_PHASE  = 2;

  logic                 clk;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_idx;
  logic [CAP_W-1:0]     cfg_wdata;

  int unsigned fail_count;
  int unsigned pending_count;
  int unsigned idle_cycles = 0;
  int          cur_phase = -1;
  bit          tx_quiet = 1'b0;
  bit          rx_quiet = 1'b0;

  cce_in_if  in_chan ();
  cce_out_if out_chan ();

  control_char_escaper dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_chan   (in_chan),
    .out_chan  (out_chan),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata)
  );

  escape_checker esc_check (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_mon        (in_chan),
    .out_mon       (out_chan),
    .cfg_we        (cfg_we),
    .cfg_idx       (cfg_idx),
    .cfg_wdata     (cfg_wdata),
    .fail_count    (fail_count),
    .pending_count (pending_count)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Watchdog: cycles without any transaction or register write
  always @(posedge clk) begin
    if ((in_chan.valid && in_chan.ready) || (out_chan.valid && out_chan.ready) || cfg_we)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // Result side: random gap before each transaction, one long hold-off in the
  // back-pressure phase
  initial begin
    int unsigned gap;
    bit          held;
    held = 1'b0;
    out_chan.ready <= 1'b0;
    @(posedge rst_n);
    @(negedge clk);
    forever begin
      gap = rx_quiet ? 0 : $urandom_range(0, 10);
      if (cur_phase == PRESSURE_PHASE && !held) begin
        gap  = HOLD_OFF_CYCLES;
        held = 1'b1;
      end
      if (gap > 0) begin
        out_chan.ready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      out_chan.ready <= 1'b1;
      do @(posedge clk); while (!(out_chan.valid && out_chan.ready));
      @(negedge clk);
    end
  end

  // Offer one byte after a random gap; returns at the falling edge after the transaction
  task automatic send_byte(input byte_t b);
    int unsigned gap;
    gap = tx_quiet ? 0 : $urandom_range(0, 10);
    if (gap > 0) begin
      in_chan.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_chan.valid   <= 1'b1;
    in_chan.in_byte <= b;
    do @(posedge clk); while (!(in_chan.valid && in_chan.ready));
    @(negedge clk);
  endtask

  // Wait until every predicted result came out, plus time for dropped bytes
  task automatic wait_idle();
    in_chan.valid <= 1'b0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input cfg_idx_t idx, input logic [CAP_W-1:0] value);
    wait_idle();
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  // Mix of printable, specially escaped, control and high bytes
  function automatic byte_t string_byte();
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return byte_t'($urandom_range(8'h20, 8'h7e));
      4, 5: begin
        case ($urandom_range(0, 4))
          0:       return CH_BSLASH;
          1:       return CH_DQUOTE;
          2:       return CH_LF;
          3:       return CH_TAB;
          default: return CH_CR;
        endcase
      end
      6, 7:    return byte_t'($urandom_range(1, 31));
      default: return byte_t'($urandom_range(128, 255));
    endcase
  endfunction

  // Control byte that takes the four-byte hex escape in plain mode
  function automatic byte_t hex_escaped_byte();
    byte_t b;
    do b = byte_t'($urandom_range(1, 31));
    while (b == CH_TAB || b == CH_LF || b == CH_CR);
    return b;
  endfunction

  task automatic send_string(input int unsigned len);
    repeat (len) send_byte(string_byte());
    send_byte(CH_NUL);
  endtask

  initial begin
    logic             plain;
    logic [CAP_W-1:0] cap;
    int unsigned      sent;
    int unsigned      len;

    in_chan.valid   <= 1'b0;
    in_chan.in_byte <= CH_NUL;
    cfg_we          <= 1'b0;
    cfg_idx         <= CFG_PLAIN_MODE;
    cfg_wdata       <= '0;
    rst_n           <= 1'b0;
    repeat (3) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Reset settings: empty string, every escape class, raw extremes
    send_byte(CH_NUL);    send_byte(CH_BSLASH); send_byte(CH_DQUOTE);
    send_byte(CH_LF);     send_byte(CH_TAB);    send_byte(CH_CR);
    send_byte(8'h01);     send_byte(8'h1f);     send_byte(8'h1b);
    send_byte(CH_SPACE);  send_byte(8'h7f);     send_byte(8'hff);
    send_byte(CH_NUL);

    // Raw mode: controls pass through, newline still escaped
    write_reg(CFG_PLAIN_MODE, '0);
    send_byte(CH_TAB); send_byte(CH_CR); send_byte(8'h1f); send_byte(CH_LF);
    send_byte(CH_NUL);

    // Zero capacity: everything truncates, terminator still emitted
    write_reg(CFG_OUT_CAPACITY, '0);
    send_byte(CH_BSLASH); send_byte(CH_NUL);

    // Escape that does not fit stops a later byte that would have fit
    write_reg(CFG_OUT_CAPACITY, 13'd4);
    send_byte(8'h61); send_byte(8'h61); send_byte(CH_BSLASH); send_byte(8'h61);
    send_byte(CH_NUL);

    // Capacity lowered below the count in the middle of a string
    write_reg(CFG_OUT_CAPACITY, 13'd256);
    send_byte(8'h61); send_byte(8'h62); send_byte(8'h63);
    write_reg(CFG_OUT_CAPACITY, 13'd2);
    send_byte(8'h64); send_byte(CH_NUL);

    // Random strings over a sweep of settings
    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0: begin plain = 1'b0; cap = 13'd8191; end
        1: begin plain = 1'b1; cap = 13'd4096; end
        2: begin plain = 1'b1; cap = 13'd8;    end
        3: begin plain = 1'b0; cap = 13'd5;    end
        4: begin plain = 1'b1; cap = 13'd2;    end
        5: begin plain = 1'b0; cap = 13'd1;    end
        default: begin
          plain = 1'($urandom_range(0, 1));
          cap   = CAP_W'($urandom_range(1, 40));
        end
      endcase
      write_reg(CFG_PLAIN_MODE, {{(CAP_W-1){1'b0}}, plain});
      write_reg(CFG_OUT_CAPACITY, cap);
      tx_quiet = ($urandom_range(0, 3) == 0);
      rx_quiet = ($urandom_range(0, 3) == 0);
      // Back-pressure: stop the result side while bytes keep coming
      if (ph == PRESSURE_PHASE)
        tx_quiet = 1'b1;
      cur_phase = ph;
      sent = 0;
      while (sent < PHASE_ITEMS) begin
        len = $urandom_range(0, 14);
        send_string(len);
        sent += len + 1;
      end
    end

    // Capacity above the limit is clamped; a short string passes in full
    write_reg(CFG_PLAIN_MODE, 13'd1);
    write_reg(CFG_OUT_CAPACITY, 13'd8191);
    tx_quiet = 1'b0;
    rx_quiet = 1'b0;
    repeat (CLAMP_ITEMS) send_byte(hex_escaped_byte());
    send_byte(8'h41);
    send_byte(CH_NUL);

    // Drain and verdict
    in_chan.valid <= 1'b0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (SETTLE_CYCLES + 2) @(posedge clk);
    if (fail_count == 0 && pending_count == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule

// ===== sim.f =====
hw/rtl/cce_pkg.sv
hw/rtl/cce_in_if.sv
hw/rtl/cce_out_if.sv
hw/rtl/cce_escape_enc.sv
hw/rtl/control_char_escaper.sv
verif/escape_checker.sv
verif/testbench.sv
